// ----- rtl/b86_mgc_enhancement_factor_top_defines.svh -----
// assertion macros for the enhancement factor block
`ifndef B86_MGC_ENHANCEMENT_FACTOR_TOP_DEFINES_SVH
`define B86_MGC_ENHANCEMENT_FACTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define B86_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define B86_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/b86_mgc_pkg.sv -----
// shared widths, codes and item types for the enhancement factor pipeline
`timescale 1ns / 1ps
`default_nettype none
package b86_mgc_pkg;

  // fixed point format of the gradient and of the results
  localparam int FRAC_BITS = 24;
  localparam int OUT_SH    = 32 - FRAC_BITS;
  localparam int SQ_SHIFT  = 2 * FRAC_BITS - 32;

  // internal magnitudes in Q.32
  localparam int Q_W   = 64;
  localparam int U_W   = 95 - 2 * FRAC_BITS;
  localparam int D_W   = U_W + 1;
  localparam int W_W   = 33;
  localparam int ROOT_STEPS = W_W;

  localparam logic [Q_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [Q_W-1:0] TWO_Q32 = 64'h0000_0002_0000_0000;

  // derivative order codes
  localparam logic [1:0] ORD_VALUE  = 2'd0;
  localparam logic [1:0] ORD_FIRST  = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;

  // configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN_GAMMA = 2'd1;
  localparam logic [31:0] GRAD_COEF_RESET = 32'd15309900;
  localparam logic [31:0] DEN_GAMMA_RESET = 32'd35747013;

  // item fields carried through the root search
  typedef struct packed {
    logic [31:0]    ax;
    logic           xneg;
    logic [1:0]     order;
    logic [U_W-1:0] u;
    logic [U_W-1:0] v;
    logic [D_W-1:0] d;
  } carry_t;

endpackage
`default_nettype wire

// ----- rtl/b86_mgc_mulq.sv -----
// two-stage Q.32 product floor(a*b/2^32), saturated to 64 bits
`timescale 1ns / 1ps
`default_nettype none
module b86_mgc_mulq (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [b86_mgc_pkg::Q_W-1:0] a,
  input  wire logic [b86_mgc_pkg::Q_W-1:0] b,
  output logic      [b86_mgc_pkg::Q_W-1:0] p
);
  import b86_mgc_pkg::*;

  logic [Q_W-1:0] ll, m1, m2, hh;
  logic [33:0]    mid;
  logic [65:0]    high;

  // partial products of the 32-bit halves
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[31:0] * b[31:0];
      m1 <= a[31:0] * b[63:32];
      m2 <= a[63:32] * b[31:0];
      hh <= a[63:32] * b[63:32];
    end
  end

  // recombine and saturate
  always_comb begin
    mid  = 34'(ll[63:32]) + 34'(m1[31:0]) + 34'(m2[31:0]);
    high = 66'(hh) + 66'(m1[63:32]) + 66'(m2[63:32]) + 66'(mid[33:32]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (high > 66'h0_ffff_ffff) ? {Q_W{1'b1}} : {high[31:0], mid[31:0]};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/b86_mgc_root_step.sv -----
// one bit of the inverse quartic root search, seven register stages
`timescale 1ns / 1ps
`default_nettype none
module b86_mgc_root_step (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [b86_mgc_pkg::W_W-1:0] mask,
  input  wire logic                        src_v,
  input  wire logic [b86_mgc_pkg::W_W-1:0] src_w,
  input  wire b86_mgc_pkg::carry_t         src_p,
  output logic                             dst_v,
  output logic      [b86_mgc_pkg::W_W-1:0] dst_w,
  output b86_mgc_pkg::carry_t              dst_p
);
  import b86_mgc_pkg::*;

  localparam int NST = 6;

  logic [W_W-1:0] cand0, cand6;
  logic [Q_W-1:0] t, t2, r;
  logic           ok;
  logic           v_q [NST];
  logic [W_W-1:0] w_q [NST];
  carry_t         p_q [NST];

  assign cand0 = src_w | mask;

  // t = cand^2, t2 = t^2, r = t2 * d
  b86_mgc_mulq u_mul_t (
    .clk(clk), .en(en), .a(Q_W'(cand0)), .b(Q_W'(cand0)), .p(t)
  );
  b86_mgc_mulq u_mul_t2 (
    .clk(clk), .en(en), .a(t), .b(t), .p(t2)
  );
  b86_mgc_mulq u_mul_r (
    .clk(clk), .en(en), .a(t2), .b(Q_W'(p_q[3].d)), .p(r)
  );

  // item valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) v_q[i] <= 1'b0;
      dst_v <= 1'b0;
    end else if (en) begin
      v_q[0] <= src_v;
      for (int i = 1; i < NST; i++) v_q[i] <= v_q[i-1];
      dst_v <= v_q[NST-1];
    end
  end

  // item payload alongside the products
  always_ff @(posedge clk) begin
    if (en) begin
      w_q[0] <= src_w;
      p_q[0] <= src_p;
      for (int i = 1; i < NST; i++) begin
        w_q[i] <= w_q[i-1];
        p_q[i] <= p_q[i-1];
      end
    end
  end

  // keep the candidate bit when the test passes, never above one
  assign cand6 = w_q[NST-1] | mask;
  assign ok    = (r <= ONE_Q32) && !(cand6[W_W-1] && (|cand6[W_W-2:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      dst_w <= ok ? cand6 : w_q[NST-1];
      dst_p <= p_q[NST-1];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/b86_mgc_enhancement_factor_top.sv -----
// throughput: one item per cycle while in_stall is low; the 33-step quartic root search (seven
//   register stages per step) sets the depth, not the rate
// a result that arrives while the output is stalled parks in a one-item skid stage
// reset: synchronous, clears all valid bits and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "b86_mgc_enhancement_factor_top_defines.svh"
module b86_mgc_enhancement_factor_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [31:0]                reduced_gradient,
  input  wire logic [1:0]                        derivative_order,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [31:0]                     enhancement,
  output logic signed [31:0]                     first_derivative,
  output logic signed [31:0]                     low_gradient_slope,
  output logic signed [31:0]                     second_derivative,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [b86_mgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import b86_mgc_pkg::*;

  localparam int NLEV = 6;

  typedef struct packed {
    logic [31:0]    ax;
    logic           xneg;
    logic [1:0]     order;
    logic [U_W-1:0] u;
    logic [U_W-1:0] v;
    logic [W_W-1:0] w;
    logic [W_W-1:0] w2;
    logic [W_W-1:0] w3;
    logic [W_W-1:0] w4;
    logic [W_W-1:0] w7;
    logic [W_W-1:0] w11;
    logic [Q_W-1:0] cu;
    logic [Q_W-1:0] ca;
    logic [Q_W-1:0] s7;
    logic [Q_W-1:0] fac;
    logic [Q_W-1:0] pm;
    logic           pneg;
    logic [Q_W-1:0] fm;
    logic [Q_W-1:0] m1;
    logic [Q_W-1:0] cw;
    logic [Q_W-1:0] dfm;
    logic [Q_W-1:0] d2m;
  } post_t;

  typedef struct packed {
    logic signed [31:0] enhancement;
    logic signed [31:0] first_derivative;
    logic signed [31:0] low_gradient_slope;
    logic signed [31:0] second_derivative;
  } res_t;

  // magnitude to signed Q.F, truncated toward zero and saturated
  function automatic logic [31:0] to_fix(input logic [Q_W-1:0] mag, input logic neg);
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] qn;
    q  = mag >> OUT_SH;
    if (q > 64'h8000_0000) qn = 64'd0 - 64'h8000_0000;
    else                   qn = 64'd0 - q;
    if (!neg) return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    return qn[31:0];
  endfunction

  logic [31:0] gradient_coefficient, denominator_gamma;
  logic        en;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_coefficient <= GRAD_COEF_RESET;
      denominator_gamma    <= DEN_GAMMA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAD_COEF: gradient_coefficient <= cfg_data;
        CFG_DEN_GAMMA: denominator_gamma    <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: magnitude and clamped order
  logic        f0_v, f1_v, f2_v, f3_v;
  logic [31:0] f0_ax, raw_x;
  logic        f0_xneg;
  logic [1:0]  f0_ord;
  logic [63:0] sq_w, f1_sq;
  carry_t      f1_p, f2_p, f3_p, root_in;
  carry_t      f1_p_next, f2_p_next;
  logic [U_W-1:0] u_f1;
  logic [Q_W-1:0] p_gu;

  assign raw_x = reduced_gradient;
  assign sq_w  = f0_ax * f0_ax;
  assign u_f1  = U_W'(f1_sq >> SQ_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else if (en) begin
      f0_v <= in_valid;
      f1_v <= f0_v;
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  // carried fields for the first two front stages
  always_comb begin
    f1_p_next       = '0;
    f1_p_next.ax    = f0_ax;
    f1_p_next.xneg  = f0_xneg;
    f1_p_next.order = f0_ord;
    f2_p_next       = f1_p;
    f2_p_next.u     = u_f1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_xneg    <= raw_x[31];
      f0_ax      <= raw_x[31] ? (~raw_x + 32'd1) : raw_x;
      f0_ord     <= (derivative_order > ORD_SECOND) ? ORD_SECOND : derivative_order;
      f1_sq      <= sq_w;
      f1_p       <= f1_p_next;
      f2_p       <= f2_p_next;
      f3_p       <= f2_p;
    end
  end

  // v = g * x^2
  b86_mgc_mulq u_mul_gu (
    .clk(clk), .en(en), .a(Q_W'(denominator_gamma)), .b(Q_W'(u_f1)), .p(p_gu)
  );

  always_comb begin
    root_in   = f3_p;
    root_in.v = p_gu[U_W-1:0];
    root_in.d = D_W'(ONE_Q32) + D_W'(p_gu[U_W-1:0]);
  end

  // inverse quartic root, one bit per step from the top
  logic           rt_v [ROOT_STEPS+1];
  logic [W_W-1:0] rt_w [ROOT_STEPS+1];
  carry_t         rt_p [ROOT_STEPS+1];

  assign rt_v[0] = f3_v;
  assign rt_w[0] = '0;
  assign rt_p[0] = root_in;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    b86_mgc_root_step u_step (
      .clk(clk), .rst(rst), .en(en),
      .mask(W_W'(1) << (ROOT_STEPS - 1 - k)),
      .src_v(rt_v[k]), .src_w(rt_w[k]), .src_p(rt_p[k]),
      .dst_v(rt_v[k+1]), .dst_w(rt_w[k+1]), .dst_p(rt_p[k+1])
    );
  end

  // back end: powers of w and the three products, each level registered in lq1 then lq2
  post_t          lv_in [NLEV+1];
  logic           vin   [NLEV+1];
  post_t          lq1   [NLEV];
  post_t          lq2   [NLEV];
  logic           lv1   [NLEV];
  logic           lv2   [NLEV];
  logic [Q_W-1:0] p_w2, p_cu, p_ca, p_vv, p_w3, p_w4, p_w7, p_fm;
  logic [Q_W-1:0] p_w11, p_m1, p_cw, p_df, p_d2;
  logic [Q_W-1:0] sub;

  assign vin[0] = rt_v[ROOT_STEPS];
  for (genvar l = 0; l < NLEV; l++) begin : g_vin
    assign vin[l+1] = lv2[l];
  end

  always_comb begin
    lv_in[0]       = '0;
    lv_in[0].ax    = rt_p[ROOT_STEPS].ax;
    lv_in[0].xneg  = rt_p[ROOT_STEPS].xneg;
    lv_in[0].order = rt_p[ROOT_STEPS].order;
    lv_in[0].u     = rt_p[ROOT_STEPS].u;
    lv_in[0].v     = rt_p[ROOT_STEPS].v;
    lv_in[0].w     = rt_w[ROOT_STEPS];
    lv_in[0].s7    = (Q_W'(rt_p[ROOT_STEPS].v) * 64'd7) >> 1;
    lv_in[0].fac   = TWO_Q32 + (Q_W'(rt_p[ROOT_STEPS].v) >> 1);

    sub             = lq2[0].s7 + (p_vv >> 2);
    lv_in[1]        = lq2[0];
    lv_in[1].w2     = p_w2[W_W-1:0];
    lv_in[1].cu     = p_cu;
    lv_in[1].ca     = p_ca;
    lv_in[1].pneg   = sub > TWO_Q32;
    lv_in[1].pm     = (sub > TWO_Q32) ? (sub - TWO_Q32) : (TWO_Q32 - sub);

    lv_in[2]        = lq2[1];
    lv_in[2].w3     = p_w3[W_W-1:0];
    lv_in[2].w4     = p_w4[W_W-1:0];

    lv_in[3]        = lq2[2];
    lv_in[3].w7     = p_w7[W_W-1:0];
    lv_in[3].fm     = p_fm;

    lv_in[4]        = lq2[3];
    lv_in[4].w11    = p_w11[W_W-1:0];
    lv_in[4].m1     = p_m1;

    lv_in[5]        = lq2[4];
    lv_in[5].cw     = p_cw;
    lv_in[5].dfm    = p_df;

    lv_in[6]        = lq2[5];
    lv_in[6].d2m    = p_d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NLEV; l++) begin
        lv1[l] <= 1'b0;
        lv2[l] <= 1'b0;
      end
    end else if (en) begin
      for (int l = 0; l < NLEV; l++) begin
        lv1[l] <= vin[l];
        lv2[l] <= lv1[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLEV; l++) begin
        lq1[l] <= lv_in[l];
        lq2[l] <= lq1[l];
      end
    end
  end

  // level 0: w^2, c*u, c*x, v^2
  b86_mgc_mulq u_mul_w2 (.clk(clk), .en(en),
    .a(Q_W'(lv_in[0].w)), .b(Q_W'(lv_in[0].w)), .p(p_w2));
  b86_mgc_mulq u_mul_cu (.clk(clk), .en(en),
    .a(Q_W'(gradient_coefficient)), .b(Q_W'(lv_in[0].u)), .p(p_cu));
  b86_mgc_mulq u_mul_ca (.clk(clk), .en(en),
    .a(Q_W'(gradient_coefficient)), .b(Q_W'(lv_in[0].ax) << OUT_SH), .p(p_ca));
  b86_mgc_mulq u_mul_vv (.clk(clk), .en(en),
    .a(Q_W'(lv_in[0].v)), .b(Q_W'(lv_in[0].v)), .p(p_vv));

  // level 1: w^3, w^4
  b86_mgc_mulq u_mul_w3 (.clk(clk), .en(en),
    .a(Q_W'(lv_in[1].w2)), .b(Q_W'(lv_in[1].w)), .p(p_w3));
  b86_mgc_mulq u_mul_w4 (.clk(clk), .en(en),
    .a(Q_W'(lv_in[1].w2)), .b(Q_W'(lv_in[1].w2)), .p(p_w4));

  // level 2: w^7, f term
  b86_mgc_mulq u_mul_w7 (.clk(clk), .en(en),
    .a(Q_W'(lv_in[2].w3)), .b(Q_W'(lv_in[2].w4)), .p(p_w7));
  b86_mgc_mulq u_mul_fm (.clk(clk), .en(en),
    .a(lv_in[2].cu), .b(Q_W'(lv_in[2].w3)), .p(p_fm));

  // level 3: w^11, c*x*w^7
  b86_mgc_mulq u_mul_w11 (.clk(clk), .en(en),
    .a(Q_W'(lv_in[3].w7)), .b(Q_W'(lv_in[3].w4)), .p(p_w11));
  b86_mgc_mulq u_mul_m1 (.clk(clk), .en(en),
    .a(lv_in[3].ca), .b(Q_W'(lv_in[3].w7)), .p(p_m1));

  // level 4: c*w^11, first derivative magnitude
  b86_mgc_mulq u_mul_cw (.clk(clk), .en(en),
    .a(Q_W'(gradient_coefficient)), .b(Q_W'(lv_in[4].w11)), .p(p_cw));
  b86_mgc_mulq u_mul_df (.clk(clk), .en(en),
    .a(lv_in[4].m1), .b(lv_in[4].fac), .p(p_df));

  // level 5: second derivative magnitude
  b86_mgc_mulq u_mul_d2 (.clk(clk), .en(en),
    .a(lv_in[5].cw), .b(lv_in[5].pm), .p(p_d2));

  // result conversion and order masking
  res_t conv, tail_res, out_res, skid_res;
  logic tail_v, skid_v, out_load;

  always_comb begin
    conv.enhancement        = to_fix(ONE_Q32 + lv_in[NLEV].fm, 1'b0);
    conv.first_derivative   = '0;
    conv.low_gradient_slope = '0;
    conv.second_derivative  = '0;
    if (lv_in[NLEV].order >= ORD_FIRST) begin
      conv.first_derivative   = to_fix(lv_in[NLEV].dfm, lv_in[NLEV].xneg);
      conv.low_gradient_slope = to_fix(Q_W'(gradient_coefficient), 1'b0);
    end
    if (lv_in[NLEV].order == ORD_SECOND) begin
      conv.second_derivative = to_fix(lv_in[NLEV].d2m, lv_in[NLEV].pneg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) tail_v <= 1'b0;
    else if (en) tail_v <= vin[NLEV];
  end

  always_ff @(posedge clk) begin
    if (en) tail_res <= conv;
  end

  // output register with a one-item skid stage
  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign out_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_load) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end else if (out_load) begin
      out_valid <= tail_v;
    end else if (tail_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_load) out_res <= skid_res;
    end else if (out_load) begin
      out_res <= tail_res;
    end else if (tail_v) begin
      skid_res <= tail_res;
    end
  end

  assign enhancement        = out_res.enhancement;
  assign first_derivative   = out_res.first_derivative;
  assign low_gradient_slope = out_res.low_gradient_slope;
  assign second_derivative  = out_res.second_derivative;

  // checks on the skid stage
  `B86_ASSERT_NOW(a_skid_behind_out, skid_v, out_valid, "skid item without output item")
  `B86_ASSERT_NEXT(a_skid_catch, out_valid && out_stall && !skid_v && tail_v, skid_v, "item lost")
  `B86_ASSERT_NEXT(a_pipe_frozen, !en, $stable(tail_v) && $stable(tail_res), "pipe moved")

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench for the enhancement factor pipeline
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import b86_mgc_pkg::*;

  localparam int  LIMIT_CYCLES = 2000000;
  localparam int  DRAIN_CYCLES = 300;
  localparam logic [63:0] SAT64 = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic signed [31:0] x;
    logic [1:0]         ord;
  } grad_item_t;

  typedef struct packed {
    logic signed [31:0] f;
    logic signed [31:0] d1;
    logic signed [31:0] slope;
    logic signed [31:0] d2;
  } factor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] reduced_gradient = '0;
  logic [1:0] derivative_order = ORD_VALUE;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] enhancement, first_derivative, low_gradient_slope, second_derivative;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRAD_COEF;
  logic [31:0] cfg_data = '0;

  // shadow copy of the coefficient registers
  logic [63:0] coef_c = {32'd0, GRAD_COEF_RESET};
  logic [63:0] coef_g = {32'd0, DEN_GAMMA_RESET};

  grad_item_t pending_items[$];
  factor_t    expected_factors[$];
  grad_item_t cur_item;
  int  errors = 0;
  int  items_in = 0;
  int  results_out = 0;
  int  cycles = 0;
  bit  sender_hold = 1'b0;
  bit  did_long_hold = 1'b0;

  b86_mgc_enhancement_factor_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .reduced_gradient(reduced_gradient), .derivative_order(derivative_order),
    .out_valid(out_valid), .out_stall(out_stall),
    .enhancement(enhancement), .first_derivative(first_derivative),
    .low_gradient_slope(low_gradient_slope), .second_derivative(second_derivative),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Q.32 product, saturated to 64 bits
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> 32;
    if (p[127:64] != 0) return SAT64;
    return p[63:0];
  endfunction

  // largest w with w^4 * d not above one
  function automatic logic [63:0] quartic_inv_root(logic [63:0] d);
    logic [63:0] lo, hi, mid, t;
    lo = 0;
    hi = ONE_Q32 + 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      t = qmul(mid, mid);
      t = qmul(t, t);
      if (qmul(t, d) <= ONE_Q32) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // magnitude to signed Q.F with saturation
  function automatic logic [31:0] to_fixed(logic [63:0] mag, bit neg);
    logic [63:0] q;
    q = mag >> OUT_SH;
    if (!neg) return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return 32'(0 - q);
  endfunction

  function automatic factor_t enhancement_of(grad_item_t it);
    factor_t r;
    logic [63:0] ax, u, v, d, w, w2, w3, w4, w7, w11, fac, sub, pm;
    logic [1:0] ord;
    bit xneg, pneg;
    xneg = it.x[31];
    ax = xneg ? (ONE_Q32 - {32'd0, it.x}) : {32'd0, it.x};
    ord = (it.ord > ORD_SECOND) ? ORD_SECOND : it.ord;
    u = (ax * ax) >> SQ_SHIFT;
    v = qmul(coef_g, u);
    d = ONE_Q32 + v;
    w = quartic_inv_root(d);
    w2 = qmul(w, w);
    w3 = qmul(w2, w);
    w4 = qmul(w2, w2);
    w7 = qmul(w3, w4);
    w11 = qmul(w7, w4);
    r = '0;
    r.f = to_fixed(ONE_Q32 + qmul(qmul(coef_c, u), w3), 1'b0);
    if (ord >= ORD_FIRST) begin
      fac = TWO_Q32 + (v >> 1);
      r.d1 = to_fixed(qmul(qmul(qmul(coef_c, ax << OUT_SH), w7), fac), xneg);
      r.slope = to_fixed(coef_c, 1'b0);
    end
    if (ord == ORD_SECOND) begin
      sub = ((7 * v) >> 1) + (qmul(v, v) >> 2);
      pneg = sub > TWO_Q32;
      pm = pneg ? (sub - TWO_Q32) : (TWO_Q32 - sub);
      r.d2 = to_fixed(qmul(qmul(coef_c, w11), pm), pneg);
    end
    return r;
  endfunction

  // sender: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_factors.push_back(enhancement_of(cur_item));
        items_in++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !sender_hold) begin
          cur_item = pending_items.pop_front();
          reduced_gradient <= cur_item.x;
          derivative_order <= cur_item.ord;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall modes plus one long hold-off
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!did_long_hold && items_in >= 300) begin
      did_long_hold = 1'b1;
      hold_left = 500;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 96);
        stall_mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    factor_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_factors.size() == 0) begin
        $error("unexpected result f=%h", enhancement);
        errors++;
      end else begin
        exp_r = expected_factors.pop_front();
        results_out++;
        if (enhancement !== exp_r.f) begin
          $error("enhancement exp %h got %h", exp_r.f, enhancement);
          errors++;
        end
        if (first_derivative !== exp_r.d1) begin
          $error("first_derivative exp %h got %h", exp_r.d1, first_derivative);
          errors++;
        end
        if (low_gradient_slope !== exp_r.slope) begin
          $error("low_gradient_slope exp %h got %h", exp_r.slope, low_gradient_slope);
          errors++;
        end
        if (second_derivative !== exp_r.d2) begin
          $error("second_derivative exp %h got %h", exp_r.d2, second_derivative);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("b86_mgc_enhancement_factor_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRAD_COEF) coef_c = {32'd0, val};
    else if (idx == CFG_DEN_GAMMA) coef_g = {32'd0, val};
  endtask

  task automatic push_item(logic [31:0] x, logic [1:0] ord);
    grad_item_t it;
    it.x = x;
    it.ord = ord;
    pending_items.push_back(it);
  endtask

  // wait until every item has gone in and every result has come out
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_factors.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_gradient();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      5, 6: return $urandom;
      7: return $urandom_range(0, 511) - 256;
      8: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return ($urandom_range(0, 1) ? 32'h1000_0000 : 32'hf000_0000)
                      ^ ($urandom & 32'h0fff_ffff);
    endcase
  endfunction

  initial begin
    logic [31:0] cs[7];
    logic [31:0] gs[7];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of x, every order, unused order code
    foreach (cs[k]) cs[k] = 0;
    push_item(32'h0000_0000, ORD_VALUE);
    push_item(32'h0000_0000, ORD_SECOND);
    push_item(32'h0100_0000, ORD_FIRST);
    push_item(32'hff00_0000, ORD_SECOND);
    push_item(32'h7fff_ffff, ORD_VALUE);
    push_item(32'h7fff_ffff, ORD_FIRST);
    push_item(32'h7fff_ffff, ORD_SECOND);
    push_item(32'h8000_0000, ORD_VALUE);
    push_item(32'h8000_0000, ORD_FIRST);
    push_item(32'h8000_0000, ORD_SECOND);
    push_item(32'h8000_0001, 2'd3);
    push_item(32'h0000_0001, 2'd3);
    push_item(32'hffff_ffff, ORD_SECOND);
    push_item(32'h0a00_0000, ORD_SECOND);
    push_item(32'hf600_0000, ORD_FIRST);
    push_item(32'h2000_0000, ORD_SECOND);
    wait_drained();

    // coefficient settings: reset, zeros, full scale, mixes, random
    cs = '{GRAD_COEF_RESET, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 32'd0,
           $urandom, $urandom};
    gs = '{DEN_GAMMA_RESET, 32'd0, 32'hffff_ffff, 32'd0, 32'hffff_ffff,
           $urandom, $urandom >> 4};
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_GRAD_COEF, cs[p]);
      write_reg(CFG_DEN_GAMMA, gs[p]);
      if (p == 6) begin
        write_reg(2'd2, $urandom);
        write_reg(2'd3, $urandom);
      end
      push_item(32'h7fff_ffff, ORD_SECOND);
      push_item(32'h8000_0000, ORD_SECOND);
      repeat (240) push_item(random_gradient(), 2'($urandom_range(0, 3)));
      // a mid-phase pause until the pipeline has drained
      if (p == 3) begin
        while (pending_items.size() > 120) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_factors.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d gradient items and %0d results over 7 coefficient settings",
             items_in, results_out);
    $display("orders 0..3, saturating extremes, full scale and zero coefficients");
    if (errors == 0) begin
      $display("b86_mgc_enhancement_factor_top verification clean");
    end else begin
      $display("b86_mgc_enhancement_factor_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/b86_mgc_pkg.sv
rtl/b86_mgc_mulq.sv
rtl/b86_mgc_root_step.sv
rtl/b86_mgc_enhancement_factor_top.sv
dv/tb_top.sv
